FILE: hdl/psd_pkg.sv
// ============================================================================
// psd_pkg
// Shared constants and handshake structs for the polar SC decoder.
// ============================================================================
package psd_pkg;

    localparam int LOG_LENGTH_DEF  = 10;
    localparam int CODE_LENGTH_DEF = 1024;
    localparam int LLR_WIDTH_DEF   = 12;
    localparam int INNER_WIDTH_DEF = 24;

    localparam int WORD_BITS   = 32;
    localparam int COUNT_WIDTH = 6;

    // status of the request queue between front and back
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // status of the decode engine
    typedef struct packed {
        logic active;
    } back_status_t;

endpackage

FILE: hdl/psd_front.sv
// ============================================================================
// psd_front
// Loader: takes channel LLRs, writes them to the engine's stores, counts
// info positions and queues a decode request after the last LLR.
// ============================================================================
module psd_front #(
    parameter int LOG_LENGTH  = psd_pkg::LOG_LENGTH_DEF,
    parameter int CODE_LENGTH = psd_pkg::CODE_LENGTH_DEF,
    parameter int LLR_WIDTH   = psd_pkg::LLR_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [LLR_WIDTH-1:0]  channel_llr,
    input  logic                         is_info,
    input  psd_pkg::queue_status_t       q_stat,
    input  psd_pkg::back_status_t        b_stat,
    output logic                         busy,
    output logic                         ld_en,
    output logic [LOG_LENGTH-1:0]        ld_addr,
    output logic signed [LLR_WIDTH-1:0]  ld_llr,
    output logic                         ld_info,
    output logic                         push,
    output logic [LOG_LENGTH:0]          push_total
);

    logic [LOG_LENGTH-1:0] count_reg, count_next;
    logic [LOG_LENGTH:0]   info_cnt_reg, info_cnt_next;
    logic                  accept;
    logic                  last_item;

    // stores are shared with the engine, so hold off while a decode is pending
    assign busy      = !q_stat.empty || b_stat.active;
    assign accept    = start && !busy;
    assign last_item = (count_reg == LOG_LENGTH'(CODE_LENGTH - 1));

    assign ld_en      = accept;
    assign ld_addr    = count_reg;
    assign ld_llr     = channel_llr;
    assign ld_info    = is_info;
    assign push       = accept && last_item && !q_stat.full;
    assign push_total = info_cnt_reg + (LOG_LENGTH + 1)'(is_info);

    always_comb
    begin
        count_next    = count_reg;
        info_cnt_next = info_cnt_reg;
        if (accept)
        begin
            if (last_item)
            begin
                count_next    = '0;
                info_cnt_next = '0;
            end
            else
            begin
                count_next    = count_reg + 1'b1;
                info_cnt_next = push_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            info_cnt_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            info_cnt_reg <= info_cnt_next;
        end
    end

endmodule

FILE: hdl/psd_queue.sv
// ============================================================================
// psd_queue
// Two-entry request queue between loader and decode engine.
// ============================================================================
module psd_queue #(
    parameter int WIDTH = psd_pkg::LOG_LENGTH_DEF + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output psd_pkg::queue_status_t q_stat
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_stat.empty = (cnt_reg == 2'd0);
    assign q_stat.full  = (cnt_reg == 2'd2);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/psd_back.sv
// ============================================================================
// psd_back
// Decode engine: one shared f/g unit walks the SC tree layer by layer,
// folds partial sums, and packs decided info bits into 32-bit words.
// ============================================================================
module psd_back #(
    parameter int LOG_LENGTH  = psd_pkg::LOG_LENGTH_DEF,
    parameter int CODE_LENGTH = psd_pkg::CODE_LENGTH_DEF,
    parameter int LLR_WIDTH   = psd_pkg::LLR_WIDTH_DEF,
    parameter int INNER_WIDTH = psd_pkg::INNER_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ld_en,
    input  logic [LOG_LENGTH-1:0]                 ld_addr,
    input  logic signed [LLR_WIDTH-1:0]           ld_llr,
    input  logic                                  ld_info,
    input  psd_pkg::queue_status_t                q_stat,
    input  logic [LOG_LENGTH:0]                   q_data,
    output logic                                  pop,
    output psd_pkg::back_status_t                 b_stat,
    output logic                                  result_valid,
    output logic [psd_pkg::WORD_BITS-1:0]         message_bits,
    output logic [psd_pkg::COUNT_WIDTH-1:0]       bit_count,
    output logic                                  last_word
);

    import psd_pkg::*;

    localparam int AW  = LOG_LENGTH;
    localparam int AW1 = LOG_LENGTH + 1;
    localparam int LW  = $clog2(LOG_LENGTH);
    localparam int W   = INNER_WIDTH;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BIT  = 6'b000010,
        S_RUN  = 6'b000100,
        S_GAP  = 6'b001000,
        S_FOLD = 6'b010000,
        S_FGAP = 6'b100000
    } state_t;

    function automatic logic [LW-1:0] trail_zeros(input logic [AW-1:0] v);
        logic [LW-1:0] t;
        t = '0;
        for (int b = AW - 1; b >= 0; b--)
        begin
            if (v[b])
            begin
                t = LW'(b);
            end
        end
        return t;
    endfunction

    function automatic logic signed [W-1:0] sat_inner(input logic signed [W:0] r);
        logic signed [W-1:0] s;
        if (r[W] != r[W-1])
        begin
            s = r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            s = r[W-1:0];
        end
        return s;
    endfunction

    // sequencer
    state_t                 state_reg, state_next;
    logic [AW-1:0]          i_reg, i_next;
    logic [LW-1:0]          k_reg, k_next;
    logic [AW-1:0]          j_reg, j_next;
    logic                   g_reg, g_next;
    logic [AW:0]            total_reg, total_next;
    logic [AW:0]            done_reg, done_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [COUNT_WIDTH-1:0] wcnt_reg, wcnt_next;

    // f/g pipeline and fold pipeline
    logic                   p_vld_reg, p_vld_next;
    logic [AW-1:0]          p_waddr_reg;
    logic                   p_g_reg;
    logic                   p_ch_reg;
    logic                   q_vld_reg, q_vld_next;
    logic [AW-1:0]          q_waddr_reg, q_waddr_next;
    logic                   q_copy_reg;
    logic                   q_hi_reg;

    // result registers
    logic                   rv_reg, rv_next;
    logic [WORD_BITS-1:0]   msg_reg, msg_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   last_reg, last_next;

    // stores
    logic signed [LLR_WIDTH-1:0] ch_mem    [CODE_LENGTH];
    logic                        info_mem  [CODE_LENGTH];
    logic signed [W-1:0]         inner_mem [CODE_LENGTH-1];
    logic                        ps0_mem   [CODE_LENGTH-1];
    logic                        ps1_mem   [CODE_LENGTH-1];

    logic signed [LLR_WIDTH-1:0] ch_a_q, ch_b_q;
    logic signed [W-1:0]         in_a_q, in_b_q;
    logic                        info_q, ps0_q, ps1_q;

    // addressing
    logic [AW1-1:0] h1, lo_base, hi_base, jx, pm;
    logic [AW-1:0]  ch_ra, ch_rb, in_ra, in_rb, ps_ra;
    logic           run_last, fold_last, fold_copy;
    logic [LW:0]    nk;

    // datapath
    logic signed [W-1:0] op_a, op_b, res;
    logic signed [W:0]   ae, be, ma, mb, mn, fv, gv;
    logic                dec_u;
    logic                ps1_we, ps1_wd;
    logic [AW-1:0]       ps1_wa;

    assign h1        = AW1'(1) << k_reg;
    assign lo_base   = h1 - 1'b1;
    assign hi_base   = (h1 << 1) - 1'b1;
    assign jx        = AW1'(j_reg);
    assign pm        = jx & (h1 - 1'b1);
    assign fold_copy = !i_reg[k_reg];
    assign run_last  = (jx == h1 - 1'b1);
    assign fold_last = fold_copy ? (jx == h1 - 1'b1) : (jx == (h1 << 1) - 1'b1);
    assign nk        = (LW + 1)'(k_reg) + 1'b1;

    assign ch_ra = AW'(jx);
    assign ch_rb = AW'(jx + h1);
    assign in_ra = AW'(hi_base + jx);
    assign in_rb = AW'(hi_base + jx + h1);
    assign ps_ra = (state_reg == S_FOLD) ? AW'(lo_base + pm) : AW'(lo_base + jx);

    // shared f/g unit on registered operands
    assign op_a = p_ch_reg ? W'(ch_a_q) : in_a_q;
    assign op_b = p_ch_reg ? W'(ch_b_q) : in_b_q;
    assign ae   = (W + 1)'(op_a);
    assign be   = (W + 1)'(op_b);
    assign ma   = op_a[W-1] ? -ae : ae;
    assign mb   = op_b[W-1] ? -be : be;
    assign mn   = (ma < mb) ? ma : mb;
    assign fv   = (op_a[W-1] ^ op_b[W-1]) ? -mn : mn;
    assign gv   = ps0_q ? (be - ae) : (ae + be);
    assign res  = sat_inner(p_g_reg ? gv : fv);

    assign dec_u = info_q && res[W-1];

    // level-0 decision writes the current bit, otherwise the fold pipe writes
    always_comb
    begin
        if (state_reg == S_GAP && k_reg == '0)
        begin
            ps1_we = 1'b1;
            ps1_wa = '0;
            ps1_wd = dec_u;
        end
        else
        begin
            ps1_we = q_vld_reg && !q_copy_reg;
            ps1_wa = q_waddr_reg;
            ps1_wd = q_hi_reg ? ps1_q : (ps0_q ^ ps1_q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            ch_mem[ld_addr]   <= ld_llr;
            info_mem[ld_addr] <= ld_info;
        end
        ch_a_q <= ch_mem[ch_ra];
        ch_b_q <= ch_mem[ch_rb];
        info_q <= info_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (p_vld_reg)
        begin
            inner_mem[p_waddr_reg] <= res;
        end
        in_a_q <= inner_mem[in_ra];
        in_b_q <= inner_mem[in_rb];
    end

    always_ff @(posedge clk)
    begin
        if (q_vld_reg && q_copy_reg)
        begin
            ps0_mem[q_waddr_reg] <= ps1_q;
        end
        if (ps1_we)
        begin
            ps1_mem[ps1_wa] <= ps1_wd;
        end
        ps0_q <= ps0_mem[ps_ra];
        ps1_q <= ps1_mem[ps_ra];
    end

    assign pop           = (state_reg == S_IDLE) && !q_stat.empty;
    assign b_stat.active = (state_reg != S_IDLE);

    always_comb
    begin
        logic [COUNT_WIDTH-1:0] wc;
        logic [AW:0]            dc;
        logic [WORD_BITS-1:0]   wd;
        logic                   bit_done;

        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        g_next     = g_reg;
        total_next = total_reg;
        done_next  = done_reg;
        word_next  = word_reg;
        wcnt_next  = wcnt_reg;
        p_vld_next = 1'b0;
        q_vld_next = 1'b0;
        q_waddr_next = fold_copy ? AW'(lo_base + jx) : AW'(hi_base + jx);
        rv_next    = 1'b0;
        msg_next   = msg_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        wc         = wcnt_reg + 1'b1;
        dc         = done_reg + 1'b1;
        wd         = word_reg | (WORD_BITS'(dec_u) << wcnt_reg[4:0]);
        bit_done   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    total_next = q_data;
                    i_next     = '0;
                    done_next  = '0;
                    word_next  = '0;
                    wcnt_next  = '0;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                k_next     = (i_reg == '0) ? LW'(LOG_LENGTH - 1) : trail_zeros(i_reg);
                g_next     = (i_reg != '0);
                j_next     = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                p_vld_next = 1'b1;
                if (run_last)
                begin
                    j_next     = '0;
                    state_next = S_GAP;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_GAP:
            begin
                if (k_reg != '0)
                begin
                    k_next     = k_reg - 1'b1;
                    g_next     = 1'b0;
                    state_next = S_RUN;
                end
                else
                begin
                    if (info_q)
                    begin
                        done_next = dc;
                        if (wc == COUNT_WIDTH'(WORD_BITS) || dc == total_reg)
                        begin
                            rv_next   = 1'b1;
                            msg_next  = wd;
                            cnt_next  = wc;
                            last_next = (dc == total_reg);
                            word_next = '0;
                            wcnt_next = '0;
                        end
                        else
                        begin
                            word_next = wd;
                            wcnt_next = wc;
                        end
                    end
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                q_vld_next = 1'b1;
                if (fold_last)
                begin
                    j_next     = '0;
                    state_next = S_FGAP;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_FGAP:
            begin
                if (fold_copy || nk == (LW + 1)'(LOG_LENGTH)
                    || (nk == (LW + 1)'(LOG_LENGTH - 1) && i_reg[LW'(nk)]))
                begin
                    bit_done = 1'b1;
                end
                else
                begin
                    k_next     = LW'(nk);
                    state_next = S_FOLD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (bit_done)
        begin
            if (i_reg == AW'(CODE_LENGTH - 1))
            begin
                if (total_reg == '0)
                begin
                    rv_next   = 1'b1;
                    msg_next  = '0;
                    cnt_next  = '0;
                    last_next = 1'b1;
                end
                state_next = S_IDLE;
            end
            else
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_BIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            g_reg     <= 1'b0;
            total_reg <= '0;
            done_reg  <= '0;
            word_reg  <= '0;
            wcnt_reg  <= '0;
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            g_reg     <= g_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            word_reg  <= word_next;
            wcnt_reg  <= wcnt_next;
            p_vld_reg <= p_vld_next;
            q_vld_reg <= q_vld_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_waddr_reg <= AW'(lo_base + jx);
        p_g_reg     <= g_reg;
        p_ch_reg    <= (k_reg == LW'(LOG_LENGTH - 1));
        q_waddr_reg <= q_waddr_next;
        q_copy_reg  <= fold_copy;
        q_hi_reg    <= (jx >= h1);
        msg_reg     <= msg_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
    end

    assign result_valid = rv_reg;
    assign message_bits = msg_reg;
    assign bit_count    = cnt_reg;
    assign last_word    = last_reg;

endmodule

FILE: hdl/polar_sc_decoder.sv
// ============================================================================
// polar_sc_decoder
// Min-sum successive-cancellation polar decoder, natural bit order.
// ============================================================================
// Usage:
//   Load: drive channel_llr and is_info with start high; a request is taken
//   on each clock edge where start is high and busy is low. Send CODE_LENGTH
//   requests, position 0 first. Busy rises the cycle after the last one and
//   stays high until the whole codeword is decoded.
//   Results: each word shows on message_bits/bit_count/last_word for exactly
//   one cycle with result_valid high; there is no back-pressure, the receiver
//   must take it. Decided info bits are packed LSB first, 32 per word, and the
//   final word carries last_word. A codeword with no info positions yields a
//   single word with bit_count zero and last_word set.
// Timing:
//   LLRs load at one per cycle while busy is low. Decoding runs one node per
//   cycle within a layer on a shared f/g unit. Per bit: a setup state, the
//   tree walk with a drain state after every layer, then the partial sum fold
//   (one entry per cycle) with a drain state after every fold level.
// Reset:
//   rst_n clears the load count, the request queue and the engine; stores are
//   not cleared and are always written before they are read.
// ============================================================================
module polar_sc_decoder #(
    parameter int LOG_LENGTH  = psd_pkg::LOG_LENGTH_DEF,
    parameter int CODE_LENGTH = psd_pkg::CODE_LENGTH_DEF,
    parameter int LLR_WIDTH   = psd_pkg::LLR_WIDTH_DEF,
    parameter int INNER_WIDTH = psd_pkg::INNER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [LLR_WIDTH-1:0]     channel_llr,
    input  logic                            is_info,
    output logic                            result_valid,
    output logic [psd_pkg::WORD_BITS-1:0]   message_bits,
    output logic [psd_pkg::COUNT_WIDTH-1:0] bit_count,
    output logic                            last_word
);

    import psd_pkg::*;

    queue_status_t               q_stat;
    back_status_t                b_stat;
    logic                        ld_en;
    logic [LOG_LENGTH-1:0]       ld_addr;
    logic signed [LLR_WIDTH-1:0] ld_llr;
    logic                        ld_info;
    logic                        push, pop;
    logic [LOG_LENGTH:0]         push_total, q_data;

    // front: loads the stores and classifies positions (info count)
    psd_front #(
        .LOG_LENGTH  (LOG_LENGTH),
        .CODE_LENGTH (CODE_LENGTH),
        .LLR_WIDTH   (LLR_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .channel_llr (channel_llr),
        .is_info     (is_info),
        .q_stat      (q_stat),
        .b_stat      (b_stat),
        .busy        (busy),
        .ld_en       (ld_en),
        .ld_addr     (ld_addr),
        .ld_llr      (ld_llr),
        .ld_info     (ld_info),
        .push        (push),
        .push_total  (push_total)
    );

    // decode requests carry the info-bit total of the codeword
    psd_queue #(
        .WIDTH (LOG_LENGTH + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_total),
        .pop       (pop),
        .pop_data  (q_data),
        .q_stat    (q_stat)
    );

    // back: SC tree walk, partial sums, word packing
    psd_back #(
        .LOG_LENGTH  (LOG_LENGTH),
        .CODE_LENGTH (CODE_LENGTH),
        .LLR_WIDTH   (LLR_WIDTH),
        .INNER_WIDTH (INNER_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ld_en        (ld_en),
        .ld_addr      (ld_addr),
        .ld_llr       (ld_llr),
        .ld_info      (ld_info),
        .q_stat       (q_stat),
        .q_data       (q_data),
        .pop          (pop),
        .b_stat       (b_stat),
        .result_valid (result_valid),
        .message_bits (message_bits),
        .bit_count    (bit_count),
        .last_word    (last_word)
    );

endmodule

FILE: hdl/psd_checker.sv
// ============================================================================
// psd_checker
// Port-level checks on the result words of the polar SC decoder.
// ============================================================================
module psd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            result_valid,
    input logic [psd_pkg::WORD_BITS-1:0]   message_bits,
    input logic [psd_pkg::COUNT_WIDTH-1:0] bit_count,
    input logic                            last_word
);

    import psd_pkg::*;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> bit_count <= COUNT_WIDTH'(WORD_BITS))
        else $error("bit_count above word size");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_word |-> bit_count == COUNT_WIDTH'(WORD_BITS))
        else $error("non-final word not full");

    a_empty_msg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bit_count == '0 |-> last_word && message_bits == '0)
        else $error("empty word not final or not zero");

    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_word |=> !result_valid)
        else $error("back-to-back result words");

endmodule

bind polar_sc_decoder psd_checker u_psd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .message_bits (message_bits),
    .bit_count    (bit_count),
    .last_word    (last_word)
);

FILE: sim/polar_decode_checker.sv
// ============================================================================
// polar_decode_checker
// Watches the request and result ports of the polar SC decoder and keeps its
// own min-sum SC decoder. Decoded words are queued per codeword and each
// strobed result is compared field by field with the oldest queued word.
// ============================================================================
module polar_decode_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic                                     busy,
    input  logic signed [psd_pkg::LLR_WIDTH_DEF-1:0] channel_llr,
    input  logic                                     is_info,
    input  logic                                     result_valid,
    input  logic [psd_pkg::WORD_BITS-1:0]            message_bits,
    input  logic [psd_pkg::COUNT_WIDTH-1:0]          bit_count,
    input  logic                                     last_word,
    output int                                       errors,
    output int                                       pending
);

    import psd_pkg::*;

    localparam int LOGN  = LOG_LENGTH_DEF;
    localparam int NCODE = CODE_LENGTH_DEF;
    localparam longint INNER_MAX = (longint'(1) <<< (INNER_WIDTH_DEF - 1)) - 1;
    localparam longint INNER_MIN = -INNER_MAX - 1;

    typedef struct packed {
        logic [WORD_BITS-1:0]   bits;
        logic [COUNT_WIDTH-1:0] count;
        logic                   last;
    } decoded_word_t;

    decoded_word_t expected_words[$];

    longint     llr_in[NCODE];
    logic       info_in[NCODE];
    longint     node_llr[NCODE-1];
    logic [1:0] psum[2*NCODE-1];
    logic       decided[NCODE];
    int         loaded;

    assign pending = expected_words.size();

    function automatic longint min_sum(longint a, longint b);
        longint ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (ma < mb) ? ma : mb;
        if (a == 0 || b == 0)
            return 0;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint combine(logic s, longint a, longint b);
        longint v;
        v = (s ? -a : a) + b;
        if (v > INNER_MAX)
            v = INNER_MAX;
        if (v < INNER_MIN)
            v = INNER_MIN;
        return v;
    endfunction

    // level LOGN is the channel, lower levels live in the node store
    function automatic longint llr_at(int lvl, int j);
        if (lvl >= LOGN)
            return llr_in[j];
        return node_llr[(1 << lvl) - 1 + j];
    endfunction

    task automatic decode_codeword();
        int t, half, h, o, po, n_info, nw, w, n;
        logic u, l, r;
        decoded_word_t dw;
        n_info = 0;
        for (int i = 0; i < NCODE; i++)
        begin
            t = 0;
            if (i == 0)
                t = LOGN - 1;
            else
                while (((i >> t) & 1) == 0)
                    t++;
            half = 1 << t;
            for (int j = 0; j < half; j++)
                node_llr[half - 1 + j] = (i == 0)
                    ? min_sum(llr_at(t + 1, j), llr_at(t + 1, j + half))
                    : combine(psum[half - 1 + j][0], llr_at(t + 1, j),
                              llr_at(t + 1, j + half));
            for (int k = t - 1; k >= 0; k--)
            begin
                h = 1 << k;
                for (int j = 0; j < h; j++)
                    node_llr[h - 1 + j] = min_sum(llr_at(k + 1, j), llr_at(k + 1, j + h));
            end
            u = 1'b0;
            if (info_in[i])
            begin
                u = (node_llr[0] < 0);
                decided[n_info] = u;
                n_info++;
            end
            // fold finished right children up the tree
            psum[0][1] = u;
            for (int k = 0; k < LOGN; k++)
            begin
                h = 1 << k;
                o = h - 1;
                if (((i >> k) & 1) == 0)
                begin
                    for (int j = 0; j < h; j++)
                        psum[o + j] = {psum[o + j][1], psum[o + j][1]};
                    break;
                end
                po = 2 * h - 1;
                for (int j = 0; j < h; j++)
                begin
                    l = psum[o + j][0];
                    r = psum[o + j][1];
                    psum[po + j][1]     = l ^ r;
                    psum[po + j + h][1] = r;
                end
            end
        end
        if (n_info == 0)
        begin
            dw = '{bits: '0, count: '0, last: 1'b1};
            expected_words.push_back(dw);
        end
        else
        begin
            nw = (n_info + WORD_BITS - 1) / WORD_BITS;
            for (w = 0; w < nw; w++)
            begin
                n = n_info - w * WORD_BITS;
                if (n > WORD_BITS)
                    n = WORD_BITS;
                dw.bits = '0;
                for (int b = 0; b < n; b++)
                    dw.bits[b] = decided[w * WORD_BITS + b];
                dw.count = COUNT_WIDTH'(n);
                dw.last  = (w == nw - 1);
                expected_words.push_back(dw);
            end
        end
    endtask

    initial
    begin
        errors = 0;
        loaded = 0;
        foreach (psum[i])
            psum[i] = '0;
        foreach (node_llr[i])
            node_llr[i] = 0;
    end

    always @(posedge clk)
    begin
        decoded_word_t exp_w;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                llr_in[loaded]  = channel_llr;
                info_in[loaded] = is_info;
                loaded++;
                if (loaded == NCODE)
                begin
                    loaded = 0;
                    decode_codeword();
                end
            end
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word bits=%h count=%0d last=%0b",
                             $time, message_bits, bit_count, last_word);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (message_bits !== exp_w.bits)
                    begin
                        $display("%0t: message_bits expected %h got %h",
                                 $time, exp_w.bits, message_bits);
                        errors++;
                    end
                    if (bit_count !== exp_w.count)
                    begin
                        $display("%0t: bit_count expected %0d got %0d",
                                 $time, exp_w.count, bit_count);
                        errors++;
                    end
                    if (last_word !== exp_w.last)
                    begin
                        $display("%0t: last_word expected %0b got %0b",
                                 $time, exp_w.last, last_word);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/polar_sc_decoder_test.sv
// ============================================================================
// polar_sc_decoder_test
// Drives whole codewords of LLRs into the polar SC decoder; a side checker
// predicts the decoded words and the top only gives the verdict.
// ============================================================================
module polar_sc_decoder_test;
    import psd_pkg::*;

    localparam int NCODE = CODE_LENGTH_DEF;

    // codeword flavors
    typedef enum int {
        CW_ALL_FROZEN,   // no info bits: single empty word
        CW_ALL_INFO,     // every position info, LLR extremes
        CW_DENSE         // mostly info, full LLR range
    } cw_kind_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic signed [LLR_WIDTH_DEF-1:0] channel_llr;
    logic                            is_info;
    logic                            result_valid;
    logic [WORD_BITS-1:0]            message_bits;
    logic [COUNT_WIDTH-1:0]          bit_count;
    logic                            last_word;
    int                              errors;
    int                              pending;

    polar_sc_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .channel_llr  (channel_llr),
        .is_info      (is_info),
        .result_valid (result_valid),
        .message_bits (message_bits),
        .bit_count    (bit_count),
        .last_word    (last_word)
    );

    polar_decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .channel_llr  (channel_llr),
        .is_info      (is_info),
        .result_valid (result_valid),
        .message_bits (message_bits),
        .bit_count    (bit_count),
        .last_word    (last_word),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Push one request. Called at a falling edge; the gap is spent first with
    // start low, so start never drops and rises within one step.
    task automatic send_request(logic signed [LLR_WIDTH_DEF-1:0] llr, logic info, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        channel_llr <= llr;
        is_info     <= info;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One full codeword; the last request kicks off decoding.
    task automatic send_codeword(cw_kind_t kind, bit no_idle);
        logic signed [LLR_WIDTH_DEF-1:0] llr;
        logic info;
        for (int i = 0; i < NCODE; i++)
        begin
            llr  = LLR_WIDTH_DEF'($urandom);
            info = 1'($urandom_range(0, 1));
            case (kind)
                CW_ALL_FROZEN: info = 1'b0;
                CW_ALL_INFO:
                begin
                    info = 1'b1;
                    case (i % 5)
                        0: llr = LLR_WIDTH_DEF'(-2048);
                        1: llr = LLR_WIDTH_DEF'(2047);
                        2: llr = '0;
                        3: llr = LLR_WIDTH_DEF'(-1);
                        default: llr = LLR_WIDTH_DEF'(1);
                    endcase
                end
                CW_DENSE:  info = ($urandom_range(0, 9) != 0);
                default: ;
            endcase
            send_request(llr, info, no_idle ? 0 : $urandom_range(0, 9));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        channel_llr = '0;
        is_info     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed codewords: special cases and LLR extremes
        send_codeword(CW_ALL_FROZEN, 1'b0);
        send_codeword(CW_ALL_INFO, 1'b1);

        // hold off until the decoder has drained everything
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);

        send_codeword(CW_DENSE, 1'b0);

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (errors == 0)
            $display("polar_sc_decoder_test: done, clean");
        else
            $display("polar_sc_decoder_test: done, errors");
        $finish;
    end

    // watchdog: three codewords take well under a tenth of this
    initial
    begin
        #20000000;
        $display("polar_sc_decoder_test: done, errors");
        $finish;
    end

endmodule
